// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define DVF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define DVF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DVF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DVF_ASSERT(lbl, clk, rst_n, prop, msg)
`define DVF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define DVF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/dvf_pkg.sv =====
// ---------------------------------------------------------------------------
// dvf_pkg
// Shared label codes, register map and control types of the direction voter.
// ---------------------------------------------------------------------------
package dvf_pkg;

    // direction label codes
    localparam logic [1:0] LBL_NONE     = 2'd0;
    localparam logic [1:0] LBL_STRAIGHT = 2'd1;
    localparam logic [1:0] LBL_LEFT     = 2'd2;
    localparam logic [1:0] LBL_RIGHT    = 2'd3;

    // configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_CAPACITY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOTE_THRESHOLD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_LIMIT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_STREAK   = 2'd3;

    localparam int CAP_W    = 5;
    localparam int THR_W    = 5;
    localparam int LIMIT_W  = 16;
    localparam int STREAK_W = 16;

    localparam logic [CAP_W-1:0]    CAP_RST    = 5'd5;
    localparam logic [THR_W-1:0]    THR_RST    = 5'd3;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 16'd30;
    localparam logic [STREAK_W-1:0] STREAK_RST = 16'd3;

    // stream payload sizes
    localparam int IN_TDATA_W  = 8;
    localparam int RES_W       = 57;
    localparam int OUT_TDATA_W = 64;
    localparam int FIELD_CNT_W = 5;
    localparam int FIELD_CTR_W = 16;

    // per-frame commands to the vote window
    typedef struct packed {
        logic step;
        logic push_model;
        logic push_vision;
        logic clear;
    } t_win_ctrl;

    // shift command common to all cells
    typedef struct packed {
        logic shift_one;
        logic shift_two;
    } t_cell_shift;

    // per-cell eviction taps
    typedef struct packed {
        logic sel_oldest;
        logic sel_next_oldest;
    } t_cell_tap;

endpackage

// ===== sv/dvf_vote_cell.sv =====
// ---------------------------------------------------------------------------
// dvf_vote_cell
// One slot of the vote shift line; on a push it shifts by one or two slots, else it holds.
// ---------------------------------------------------------------------------
module dvf_vote_cell (
    input  logic                i_clk,
    input  dvf_pkg::t_cell_shift i_shift,
    input  dvf_pkg::t_cell_tap   i_tap,
    input  logic [1:0]          i_prev1,
    input  logic [1:0]          i_prev2,
    output logic [1:0]          o_vote,
    output logic [1:0]          o_tap_oldest,
    output logic [1:0]          o_tap_next_oldest
);
    import dvf_pkg::*;

    logic [1:0] r_vote;
    logic [1:0] n_vote;

    // take from one or two slots upstream
    always_comb begin
        n_vote = r_vote;
        if (i_shift.shift_two) begin
            n_vote = i_prev2;
        end else if (i_shift.shift_one) begin
            n_vote = i_prev1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vote <= n_vote;
    end

    assign o_vote            = r_vote;
    assign o_tap_oldest      = i_tap.sel_oldest      ? r_vote : LBL_NONE;
    assign o_tap_next_oldest = i_tap.sel_next_oldest ? r_vote : LBL_NONE;

endmodule

// ===== sv/dvf_vote_window.sv =====
// ---------------------------------------------------------------------------
// dvf_vote_window
// Sliding vote window: chain of cells, newest vote at cell 0, plus tallies.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dvf_vote_window #(
    parameter int DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dvf_pkg::t_win_ctrl                 i_ctrl,
    input  logic [1:0]                         i_model,
    input  logic [1:0]                         i_vision,
    input  logic [dvf_pkg::CAP_W-1:0]          i_capacity,
    output logic [$clog2(DEPTH+1)-1:0]         o_occ_next,
    output logic [$clog2(DEPTH+1)-1:0]         o_straight_next,
    output logic [$clog2(DEPTH+1)-1:0]         o_left_next,
    output logic [$clog2(DEPTH+1)-1:0]         o_right_next
);
    import dvf_pkg::*;

    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int CW    = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam int SUM_W = OCC_W + 2;

    logic [OCC_W-1:0] r_occ;
    logic [OCC_W-1:0] r_straight;
    logic [OCC_W-1:0] r_left;
    logic [OCC_W-1:0] r_right;
    logic [OCC_W-1:0] n_occ;
    logic [OCC_W-1:0] n_straight;
    logic [OCC_W-1:0] n_left;
    logic [OCC_W-1:0] n_right;

    logic [CW-1:0] cap_ext;
    logic [CW-1:0] cap_eff;
    logic [CW-1:0] occ0;
    logic [CW-1:0] occ1;
    logic [CW-1:0] occ2;
    logic [CW-1:0] tail1;
    logic [CW-1:0] tail2;
    logic          push1;
    logic          push2;
    logic          ev1;
    logic          ev2;
    logic [1:0]    ev_lbl1;
    logic [1:0]    ev_lbl2;

    t_cell_shift   shift;
    logic [1:0]    w_vote  [DEPTH];
    logic [1:0]    w_tap1  [DEPTH];
    logic [1:0]    w_tap2  [DEPTH];
    logic [SUM_W-1:0] tally_sum;

    // decrement on eviction (never below zero), then count the new vote
    function automatic logic [OCC_W-1:0] bump(input logic [OCC_W-1:0] t,
                                              input logic dn, input logic up);
        logic [OCC_W-1:0] v;
        v = t;
        if (dn && (v != '0)) begin
            v = v - OCC_W'(1);
        end
        if (up) begin
            v = v + OCC_W'(1);
        end
        return v;
    endfunction

    // effective capacity and occupancy after each of the two pushes
    always_comb begin
        cap_ext = CW'(i_capacity);
        cap_eff = (cap_ext > CW'(DEPTH)) ? CW'(DEPTH) : cap_ext;
        occ0    = CW'(r_occ);
        push1   = i_ctrl.step && i_ctrl.push_model  && (cap_eff != '0);
        push2   = i_ctrl.step && i_ctrl.push_vision && (cap_eff != '0);
        ev1     = push1 && (occ0 >= cap_eff) && (occ0 != '0);
        occ1    = occ0;
        if (push1 && !ev1) begin
            occ1 = occ0 + CW'(1);
        end
        ev2  = push2 && (occ1 >= cap_eff);
        occ2 = occ1;
        if (push2 && !ev2) begin
            occ2 = occ1 + CW'(1);
        end
        // oldest slot before the first push, and after it (shifted by one)
        tail1 = occ0 - CW'(1);
        tail2 = occ1 - CW'(2);
    end

    assign shift.shift_two = push2;
    assign shift.shift_one = push1 && !push2;

    // cell chain
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [1:0] prev1;
        logic [1:0] prev2;
        t_cell_tap  tap;

        if (k == 0) begin : g_head
            assign prev1 = i_model;
            assign prev2 = i_vision;
        end else if (k == 1) begin : g_second
            assign prev1 = w_vote[0];
            assign prev2 = i_model;
        end else begin : g_body
            assign prev1 = w_vote[k-1];
            assign prev2 = w_vote[k-2];
        end

        assign tap.sel_oldest      = ev1 && (tail1 == CW'(k));
        assign tap.sel_next_oldest = ev2 && (occ1 >= CW'(2)) && (tail2 == CW'(k));

        dvf_vote_cell u_cell (
            .i_clk             (i_clk),
            .i_shift           (shift),
            .i_tap             (tap),
            .i_prev1           (prev1),
            .i_prev2           (prev2),
            .o_vote            (w_vote[k]),
            .o_tap_oldest      (w_tap1[k]),
            .o_tap_next_oldest (w_tap2[k])
        );
    end

    // gather evicted votes from the one-hot taps
    always_comb begin
        ev_lbl1 = LBL_NONE;
        ev_lbl2 = LBL_NONE;
        for (int k = 0; k < DEPTH; k++) begin
            ev_lbl1 = ev_lbl1 | w_tap1[k];
            ev_lbl2 = ev_lbl2 | w_tap2[k];
        end
        // second push evicting the vote the first push just placed
        if (ev2 && (occ1 == CW'(1))) begin
            ev_lbl2 = i_model;
        end
    end

    // tally update, first push then second
    always_comb begin
        n_straight = bump(r_straight, ev1 && (ev_lbl1 == LBL_STRAIGHT),
                          push1 && (i_model == LBL_STRAIGHT));
        n_left     = bump(r_left, ev1 && (ev_lbl1 == LBL_LEFT),
                          push1 && (i_model == LBL_LEFT));
        n_right    = bump(r_right, ev1 && (ev_lbl1 == LBL_RIGHT),
                          push1 && (i_model == LBL_RIGHT));
        n_straight = bump(n_straight, ev2 && (ev_lbl2 == LBL_STRAIGHT),
                          push2 && (i_vision == LBL_STRAIGHT));
        n_left     = bump(n_left, ev2 && (ev_lbl2 == LBL_LEFT),
                          push2 && (i_vision == LBL_LEFT));
        n_right    = bump(n_right, ev2 && (ev_lbl2 == LBL_RIGHT),
                          push2 && (i_vision == LBL_RIGHT));
        n_occ      = occ2[OCC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_occ      <= '0;
            r_straight <= '0;
            r_left     <= '0;
            r_right    <= '0;
        end else begin
            r_occ      <= n_occ;
            r_straight <= n_straight;
            r_left     <= n_left;
            r_right    <= n_right;
        end
    end

    assign o_occ_next      = n_occ;
    assign o_straight_next = n_straight;
    assign o_left_next     = n_left;
    assign o_right_next    = n_right;

    assign tally_sum = SUM_W'(r_straight) + SUM_W'(r_left) + SUM_W'(r_right);

    // every held vote is counted once
    `DVF_ASSERT(a_tally_sum, i_clk, i_rst_n, tally_sum == SUM_W'(r_occ), "tally sum mismatch")
    `DVF_ASSERT(a_occ_bound, i_clk, i_rst_n, r_occ <= OCC_W'(DEPTH), "window overfilled")

endmodule

// ===== sv/dvf_out_skid.sv =====
// ---------------------------------------------------------------------------
// dvf_out_skid
// Two-entry result buffer: output register plus skid slot.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dvf_out_skid #(
    parameter int DATA_W = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_data
);
    logic              r_out_valid;
    logic              r_skid_valid;
    logic [DATA_W-1:0] r_out_data;
    logic [DATA_W-1:0] r_skid_data;
    logic              in_fire;
    logic              out_free;

    assign o_ready  = !r_skid_valid;
    assign in_fire  = i_valid && !r_skid_valid;
    assign out_free = !r_out_valid || i_ready;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || in_fire;
            r_skid_valid <= 1'b0;
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_data;
        end else if (in_fire) begin
            r_skid_data <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    // skid slot is only used behind a full output register
    `DVF_ASSERT_IMP(a_skid_order, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid without output")

endmodule

// ===== sv/direction_vote_with_fallback_unit.sv =====
// ---------------------------------------------------------------------------
// direction_vote_with_fallback_unit
// Direction voter over model/vision labels with vision streak fallback.
// ---------------------------------------------------------------------------
// The block takes one frame per clock cycle while s_axis_tready is high and
// registers its result in the output register of a two-entry output buffer,
// so input keeps flowing for one extra frame while the result side stalls,
// that result waiting in the skid slot. The vote window is a chain of
// WINDOW_DEPTH cells shifting by one or two votes, with tallies adjusted in
// the same cycle. No clearing pass is needed after reset. Configuration is
// written through i_cfg_we/i_cfg_idx/i_cfg_data and should only change while
// no frame is in flight.
`include "assert_macros.svh"

module direction_vote_with_fallback_unit #(
    parameter int WINDOW_DEPTH = 16,
    parameter int COUNTER_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [dvf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dvf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // frame input
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] restart, [2:1] model_dir, [4:3] vision_dir, [7:5] zero
    input  logic [dvf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // result output
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [1:0] decision, [2] in_fallback, [18:3] frames_seen, [23:19] votes_held,
    // [28:24] straight_votes, [33:29] left_votes, [38:34] right_votes,
    // [40:39] streak_label, [56:41] streak_count, [63:57] zero
    output logic [dvf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import dvf_pkg::*;

    localparam int OCC_W = $clog2(WINDOW_DEPTH + 1);
    localparam int CB    = COUNTER_BITS;
    localparam int CMP_W = (CB > FIELD_CTR_W) ? CB : FIELD_CTR_W;
    localparam int OW    = (OCC_W > FIELD_CNT_W) ? OCC_W : FIELD_CNT_W;
    localparam int TW    = (OCC_W > THR_W) ? OCC_W : THR_W;
    localparam logic [CB-1:0] CTR_MAX = {CB{1'b1}};

    // configuration registers
    logic [CAP_W-1:0]    r_capacity;
    logic [THR_W-1:0]    r_threshold;
    logic [LIMIT_W-1:0]  r_limit;
    logic [STREAK_W-1:0] r_streak_len;

    // frame state
    logic          r_started;
    logic          r_fallback;
    logic [CB-1:0] r_frames;
    logic [1:0]    r_cand;
    logic [CB-1:0] r_run;
    logic          n_started;
    logic          n_fallback;
    logic [CB-1:0] n_frames;
    logic [1:0]    n_cand;
    logic [CB-1:0] n_run;

    logic       s_fire;
    logic       in_restart;
    logic [1:0] in_model;
    logic [1:0] in_vision;
    logic       both_turn;
    logic       active;
    logic       clear_win;
    logic       push_model;
    logic       push_vision;
    logic [1:0] decision;
    logic [1:0] winner;

    t_win_ctrl        win_ctrl;
    logic [OCC_W-1:0] occ_next;
    logic [OCC_W-1:0] straight_next;
    logic [OCC_W-1:0] left_next;
    logic [OCC_W-1:0] right_next;
    logic [OW-1:0]    held_ext;
    logic [OW-1:0]    straight_ext;
    logic [OW-1:0]    left_ext;
    logic [OW-1:0]    right_ext;
    logic [CMP_W-1:0] frames_ext;
    logic [CMP_W-1:0] run_ext;
    logic [RES_W-1:0] result;
    logic             out_in_ready;

    function automatic logic is_turn(input logic [1:0] lbl);
        return (lbl == LBL_LEFT) || (lbl == LBL_RIGHT);
    endfunction

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= CAP_RST;
            r_threshold  <= THR_RST;
            r_limit      <= LIMIT_RST;
            r_streak_len <= STREAK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WINDOW_CAPACITY: r_capacity   <= i_cfg_data[CAP_W-1:0];
                CFG_VOTE_THRESHOLD:  r_threshold  <= i_cfg_data[THR_W-1:0];
                CFG_FALLBACK_LIMIT:  r_limit      <= i_cfg_data[LIMIT_W-1:0];
                CFG_FALLBACK_STREAK: r_streak_len <= i_cfg_data[STREAK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input unpack
    assign s_axis_tready = out_in_ready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign in_restart    = s_axis_tdata[0];
    assign in_model      = s_axis_tdata[2:1];
    assign in_vision     = s_axis_tdata[4:3];
    assign both_turn     = is_turn(in_model) && is_turn(in_vision);
    assign active        = !in_restart && (r_started || (in_model != LBL_NONE));

    // vote window
    assign win_ctrl.step        = s_fire;
    assign win_ctrl.push_model  = push_model;
    assign win_ctrl.push_vision = push_vision;
    assign win_ctrl.clear       = s_fire && clear_win;

    dvf_vote_window #(
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (win_ctrl),
        .i_model         (in_model),
        .i_vision        (in_vision),
        .i_capacity      (r_capacity),
        .o_occ_next      (occ_next),
        .o_straight_next (straight_next),
        .o_left_next     (left_next),
        .o_right_next    (right_next)
    );

    // winner on the updated tallies, straight first
    always_comb begin
        winner = LBL_NONE;
        if (r_threshold != '0) begin
            if (TW'(straight_next) >= TW'(r_threshold)) begin
                winner = LBL_STRAIGHT;
            end else if (TW'(left_next) >= TW'(r_threshold)) begin
                winner = LBL_LEFT;
            end else if (TW'(right_next) >= TW'(r_threshold)) begin
                winner = LBL_RIGHT;
            end
        end
    end

    // per-frame decision and next state
    always_comb begin
        n_started   = r_started;
        n_fallback  = r_fallback;
        n_frames    = r_frames;
        n_cand      = r_cand;
        n_run       = r_run;
        decision    = LBL_NONE;
        push_model  = 1'b0;
        push_vision = 1'b0;
        clear_win   = 1'b0;
        if (in_restart) begin
            n_started  = 1'b0;
            n_fallback = 1'b0;
            n_frames   = '0;
            n_cand     = LBL_NONE;
            n_run      = '0;
            clear_win  = 1'b1;
        end else if (active) begin
            n_started = 1'b1;
            if (r_frames != CTR_MAX) begin
                n_frames = r_frames + CB'(1);
            end
            if (r_fallback) begin
                // vision streak
                if (both_turn) begin
                    if (in_vision == r_cand) begin
                        if (r_run != CTR_MAX) begin
                            n_run = r_run + CB'(1);
                        end
                    end else begin
                        n_cand = in_vision;
                        n_run  = CB'(1);
                    end
                    if ((r_streak_len != '0) &&
                        (CMP_W'(n_run) >= CMP_W'(r_streak_len))) begin
                        decision = n_cand;
                    end
                end else begin
                    n_cand = LBL_NONE;
                    n_run  = '0;
                end
            end else begin
                // voting
                push_model  = (in_model != LBL_NONE);
                push_vision = both_turn;
                if (winner != LBL_NONE) begin
                    decision = winner;
                end else if (CMP_W'(n_frames) >= CMP_W'(r_limit)) begin
                    n_fallback = 1'b1;
                    clear_win  = 1'b1;
                    n_cand     = LBL_NONE;
                    n_run      = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started  <= 1'b0;
            r_fallback <= 1'b0;
            r_frames   <= '0;
            r_cand     <= LBL_NONE;
            r_run      <= '0;
        end else if (s_fire) begin
            r_started  <= n_started;
            r_fallback <= n_fallback;
            r_frames   <= n_frames;
            r_cand     <= n_cand;
            r_run      <= n_run;
        end
    end

    // status after the frame, window cleared where this frame clears it
    assign held_ext     = clear_win ? '0 : OW'(occ_next);
    assign straight_ext = clear_win ? '0 : OW'(straight_next);
    assign left_ext     = clear_win ? '0 : OW'(left_next);
    assign right_ext    = clear_win ? '0 : OW'(right_next);
    assign frames_ext   = CMP_W'(n_frames);
    assign run_ext      = CMP_W'(n_run);

    assign result = {run_ext[FIELD_CTR_W-1:0], n_cand,
                     right_ext[FIELD_CNT_W-1:0], left_ext[FIELD_CNT_W-1:0],
                     straight_ext[FIELD_CNT_W-1:0], held_ext[FIELD_CNT_W-1:0],
                     frames_ext[FIELD_CTR_W-1:0], n_fallback, decision};

    dvf_out_skid #(
        .DATA_W (OUT_TDATA_W)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (out_in_ready),
        .i_data  ({{(OUT_TDATA_W-RES_W){1'b0}}, result}),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

    // restart transaction returns the frame state to its reset value
    `DVF_ASSERT_NXT(a_restart_clears, i_clk, i_rst_n, s_fire && in_restart, (r_frames == '0) && !r_started && !r_fallback, "restart did not clear state")
    // a streak candidate exists exactly while the run is nonzero
    `DVF_ASSERT(a_streak_pair, i_clk, i_rst_n, (r_run == '0) == (r_cand == LBL_NONE), "streak label and count disagree")

endmodule
